>>> design/rtrp_pkg.sv
// Shared widths, register indexes and descriptor types of the rank task range partitioner.
package rtrp_pkg;

   // configuration register widths
   localparam int K_W       = 7;
   localparam int ATOM_W    = 5;
   localparam int WORKER_W  = 11;
   localparam int INDEX_W   = 10;

   // internal widths, set by the register widths above
   localparam int KIDX_W    = 6;                    // k-point index below 64
   localparam int PAIR_W    = 2 * ATOM_W;           // pair count up to 31*31
   localparam int POS_W     = 16;                   // task position up to 64*961
   localparam int DIV_NUM_W = POS_W + INDEX_W;      // task count times worker index
   localparam int DIV_DEN_W = WORKER_W;
   localparam int DIV_STEPS  = 2;                   // quotient bits per cycle
   localparam int DIV_CYCLES = DIV_NUM_W / DIV_STEPS;
   localparam int DIV_CNT_W  = $clog2(DIV_CYCLES + 1);

   // result field widths
   localparam int KP_W  = 7;
   localparam int PLO_W = 8;
   localparam int PHI_W = 9;
   localparam int ACT_W = 11;

   localparam int REQ_TDATA_W = 16;
   localparam int RSP_TDATA_W = 40;

   localparam int QUEUE_DEPTH = 2;

   // register indexes on the csr port
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_K_POINTS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_ATOMS    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_WORKERS  = 2'd2;

   // default bounds
   localparam int DEF_MAX_K_POINTS = 64;
   localparam int DEF_MAX_ATOMS    = 16;
   localparam int DEF_MAX_WORKERS  = 1024;

   // one classified request, handed from front to back
   typedef struct packed {
      logic                idle;
      logic                task_mode;
      logic [KIDX_W-1:0]   k_first;
      logic [K_W-1:0]      k_end;
      logic [PAIR_W-1:0]   pair_first;
      logic [POS_W-1:0]    hi_pos;
      logic [POS_W-1:0]    base_first;
      logic [PAIR_W-1:0]   pairs;
      logic [ACT_W-1:0]    act;
   } rtrp_desc_type;

   // one result word
   typedef struct packed {
      logic [KP_W-1:0]   k_point;
      logic [PLO_W-1:0]  pair_low;
      logic [PHI_W-1:0]  pair_high;
      logic [ACT_W-1:0]  active_workers;
      logic              idle;
      logic              last_piece;
   } rtrp_piece_type;

endpackage

>>> design/rtrp_div.sv
// Iterative restoring divider, two quotient bits per cycle.
module rtrp_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [rtrp_pkg::DIV_NUM_W-1:0] num,
   input  logic [rtrp_pkg::DIV_DEN_W-1:0] den,
   output logic                           done,
   output logic [rtrp_pkg::DIV_NUM_W-1:0] quo,
   output logic [rtrp_pkg::DIV_DEN_W-1:0] rem
);

   localparam int NW = rtrp_pkg::DIV_NUM_W;
   localparam int DW = rtrp_pkg::DIV_DEN_W;

   logic                           run_ff, run_in;
   logic                           done_ff, done_in;
   logic [rtrp_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [NW-1:0]                  quo_ff, quo_in;
   logic [DW-1:0]                  rem_ff, rem_in;
   logic [NW-1:0]                  q_step;
   logic [DW-1:0]                  r_step;
   logic [DW:0]                    trial;

   always_comb begin
      q_step = quo_ff;
      r_step = rem_ff;
      trial  = '0;
      for (int i = 0; i < rtrp_pkg::DIV_STEPS; i++) begin
         trial  = {r_step, q_step[NW-1]};
         q_step = {q_step[NW-2:0], 1'b0};
         if (trial >= {1'b0, den}) begin
            r_step    = DW'(trial - {1'b0, den});
            q_step[0] = 1'b1;
         end else begin
            r_step = trial[DW-1:0];
         end
      end
   end

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      if (run_ff) begin
         quo_in = q_step;
         rem_in = r_step;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == rtrp_pkg::DIV_CNT_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end else if (start) begin
         quo_in = num;
         rem_in = '0;
         cnt_in = rtrp_pkg::DIV_CNT_W'(rtrp_pkg::DIV_CYCLES);
         run_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign done = done_ff;
   assign quo  = quo_ff;
   assign rem  = rem_ff;

endmodule

>>> design/rtrp_queue.sv
// Short descriptor queue between the classifying front and the piece emitter.
module rtrp_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  rtrp_pkg::rtrp_desc_type push_data,
   output logic                    full,
   input  logic                    pop,
   output rtrp_pkg::rtrp_desc_type pop_data,
   output logic                    not_empty
);

   localparam int DEPTH = rtrp_pkg::QUEUE_DEPTH;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   rtrp_pkg::rtrp_desc_type mem_ff [DEPTH];
   logic [PTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic                    do_push, do_pop;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign pop_data  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> design/rtrp_front.sv
// Request front: takes a worker index, works out its task range and queues a descriptor.
module rtrp_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [rtrp_pkg::INDEX_W-1:0]  worker_index,
   input  logic [rtrp_pkg::K_W-1:0]      num_k_points,
   input  logic [rtrp_pkg::ATOM_W-1:0]   num_atoms,
   input  logic [rtrp_pkg::WORKER_W-1:0] num_workers,
   output logic                          desc_valid,
   input  logic                          desc_full,
   output rtrp_pkg::rtrp_desc_type       desc
);

   localparam int NW   = rtrp_pkg::DIV_NUM_W;
   localparam int DW   = rtrp_pkg::DIV_DEN_W;
   localparam int PW   = rtrp_pkg::POS_W;
   localparam int PRW  = rtrp_pkg::PAIR_W;
   localparam int KW   = rtrp_pkg::K_W;
   localparam int KIW  = rtrp_pkg::KIDX_W;
   localparam int IW   = rtrp_pkg::INDEX_W;
   localparam int WW   = rtrp_pkg::WORKER_W;

   localparam logic [3:0] F_IDLE   = 4'd0;
   localparam logic [3:0] F_MULP   = 4'd1;
   localparam logic [3:0] F_MULT   = 4'd2;
   localparam logic [3:0] F_DECIDE = 4'd3;
   localparam logic [3:0] F_MULW   = 4'd4;
   localparam logic [3:0] F_DIVLO  = 4'd5;
   localparam logic [3:0] F_DIVHI  = 4'd6;
   localparam logic [3:0] F_DIVK   = 4'd7;
   localparam logic [3:0] F_PUSH   = 4'd8;

   logic [3:0]      state_ff, state_in;
   logic [IW-1:0]   w_ff, w_in;
   logic [PRW-1:0]  p_ff, p_in;
   logic [PW-1:0]   t_ff, t_in;
   logic [DW-1:0]   den_ff, den_in;
   logic [PW-1:0]   base_ff, base_in;
   logic [NW-1:0]   prod_ff, prod_in;
   logic            mode_k_ff, mode_k_in;
   logic            idle_ff, idle_in;
   logic [PW-1:0]   lo_ff, lo_in;
   logic [PW-1:0]   hi_ff, hi_in;
   logic [KIW-1:0]  kf_ff, kf_in;
   logic [PRW-1:0]  rem_ff, rem_in;
   logic            div_run_ff, div_run_in;

   logic            div_start, div_done;
   logic [NW-1:0]   div_num, div_quo;
   logic [DW-1:0]   div_den, div_rem;

   logic            size_zero, mode_k, out_of_range;
   logic [WW-1:0]   act_split, den_pick;
   logic [PW-1:0]   base_pick;

   rtrp_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo),
      .rem   (div_rem)
   );

   // classification, from the registered pair and task counts
   always_comb begin
      size_zero    = (num_k_points == '0) || (num_atoms == '0) || (num_workers == '0);
      mode_k       = (num_workers <= WW'(num_k_points));
      act_split    = (PW'(num_workers) < t_ff) ? num_workers : WW'(t_ff);
      den_pick     = mode_k ? num_workers : act_split;
      base_pick    = mode_k ? PW'(num_k_points) : t_ff;
      out_of_range = (WW'(w_ff) >= den_pick);
   end

   // divider operands per step
   always_comb begin
      case (state_ff)
         F_DIVHI: begin
            div_num = prod_ff + NW'(base_ff);
            div_den = den_ff;
         end
         F_DIVK: begin
            div_num = NW'(lo_ff);
            div_den = DW'(p_ff);
         end
         default: begin
            div_num = prod_ff;
            div_den = den_ff;
         end
      endcase
   end

   always_comb begin
      state_in   = state_ff;
      w_in       = w_ff;
      p_in       = p_ff;
      t_in       = t_ff;
      den_in     = den_ff;
      base_in    = base_ff;
      prod_in    = prod_ff;
      mode_k_in  = mode_k_ff;
      idle_in    = idle_ff;
      lo_in      = lo_ff;
      hi_in      = hi_ff;
      kf_in      = kf_ff;
      rem_in     = rem_ff;
      div_run_in = div_run_ff;
      div_start  = 1'b0;

      case (state_ff)
         F_IDLE: begin
            if (req_valid) begin
               w_in     = worker_index;
               idle_in  = 1'b0;
               rem_in   = '0;
               state_in = F_MULP;
            end
         end
         F_MULP: begin
            p_in     = PRW'(num_atoms) * PRW'(num_atoms);
            state_in = F_MULT;
         end
         F_MULT: begin
            t_in     = PW'(PW'(num_k_points) * PW'(p_ff));
            state_in = F_DECIDE;
         end
         F_DECIDE: begin
            mode_k_in = mode_k;
            den_in    = den_pick;
            base_in   = base_pick;
            if (size_zero || out_of_range) begin
               idle_in  = 1'b1;
               state_in = F_PUSH;
            end else begin
               state_in = F_MULW;
            end
         end
         F_MULW: begin
            prod_in  = NW'(base_ff) * NW'(w_ff);
            state_in = F_DIVLO;
         end
         F_DIVLO, F_DIVHI, F_DIVK: begin
            if (!div_run_ff) begin
               div_start  = 1'b1;
               div_run_in = 1'b1;
            end else if (div_done) begin
               div_run_in = 1'b0;
               case (state_ff)
                  F_DIVLO: begin
                     lo_in    = PW'(div_quo);
                     state_in = F_DIVHI;
                  end
                  F_DIVHI: begin
                     hi_in = PW'(div_quo);
                     if (mode_k_ff) begin
                        kf_in    = lo_ff[KIW-1:0];
                        state_in = F_PUSH;
                     end else begin
                        state_in = F_DIVK;
                     end
                  end
                  default: begin
                     kf_in    = KIW'(div_quo);
                     rem_in   = PRW'(div_rem);
                     state_in = F_PUSH;
                  end
               endcase
            end
         end
         F_PUSH: begin
            if (!desc_full) begin
               state_in = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= F_IDLE;
         div_run_ff <= 1'b0;
         idle_ff    <= 1'b0;
         mode_k_ff  <= 1'b0;
      end else begin
         state_ff   <= state_in;
         div_run_ff <= div_run_in;
         idle_ff    <= idle_in;
         mode_k_ff  <= mode_k_in;
      end
      w_ff    <= w_in;
      p_ff    <= p_in;
      t_ff    <= t_in;
      den_ff  <= den_in;
      base_ff <= base_in;
      prod_ff <= prod_in;
      lo_ff   <= lo_in;
      hi_ff   <= hi_in;
      kf_ff   <= kf_in;
      rem_ff  <= rem_in;
   end

   assign req_ready  = (state_ff == F_IDLE);
   assign desc_valid = (state_ff == F_PUSH);

   always_comb begin
      desc.idle       = idle_ff;
      desc.task_mode  = !mode_k_ff;
      desc.k_first    = kf_ff;
      desc.k_end      = KW'(hi_ff);
      desc.pair_first = rem_ff;
      desc.hi_pos     = hi_ff;
      desc.base_first = lo_ff - PW'(rem_ff);
      desc.pairs      = p_ff;
      desc.act        = den_ff;
   end

endmodule

>>> design/rtrp_back.sv
// Piece emitter: walks one descriptor a k-point at a time into the result register.
module rtrp_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     desc_valid,
   input  rtrp_pkg::rtrp_desc_type  desc,
   output logic                     desc_pop,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output rtrp_pkg::rtrp_piece_type rsp_piece
);

   localparam int PW  = rtrp_pkg::POS_W;
   localparam int KIW = rtrp_pkg::KIDX_W;

   logic                     busy_ff, busy_in;
   rtrp_pkg::rtrp_desc_type  cur_ff, cur_in;
   logic [KIW-1:0]           k_ff, k_in;
   logic [PW-1:0]            base_ff, base_in;
   logic                     first_ff, first_in;
   logic                     ovalid_ff, ovalid_in;
   rtrp_pkg::rtrp_piece_type opiece_ff, opiece_in;

   rtrp_pkg::rtrp_piece_type piece;
   logic [PW:0]              bound;
   logic [rtrp_pkg::K_W-1:0] k_next;
   logic                     out_free;

   assign out_free = !ovalid_ff || rsp_ready;
   assign k_next   = rtrp_pkg::K_W'(k_ff) + 1'b1;
   assign bound    = {1'b0, base_ff} + (PW + 1)'(cur_ff.pairs);

   // current piece
   always_comb begin
      piece = '0;
      if (cur_ff.idle) begin
         piece.idle       = 1'b1;
         piece.last_piece = 1'b1;
      end else begin
         piece.k_point        = k_next;
         piece.active_workers = cur_ff.act;
         piece.pair_low       = first_ff ? rtrp_pkg::PLO_W'(cur_ff.pair_first) : '0;
         if (cur_ff.task_mode) begin
            piece.last_piece = ({1'b0, cur_ff.hi_pos} <= bound);
            piece.pair_high  = piece.last_piece ?
                               rtrp_pkg::PHI_W'(cur_ff.hi_pos - base_ff) :
                               rtrp_pkg::PHI_W'(cur_ff.pairs);
         end else begin
            piece.last_piece = (k_next == cur_ff.k_end);
            piece.pair_high  = rtrp_pkg::PHI_W'(cur_ff.pairs);
         end
      end
   end

   always_comb begin
      busy_in   = busy_ff;
      cur_in    = cur_ff;
      k_in      = k_ff;
      base_in   = base_ff;
      first_in  = first_ff;
      ovalid_in = ovalid_ff && !rsp_ready;
      opiece_in = opiece_ff;
      desc_pop  = 1'b0;

      if (busy_ff) begin
         if (out_free) begin
            ovalid_in = 1'b1;
            opiece_in = piece;
            if (piece.last_piece) begin
               busy_in = 1'b0;
            end else begin
               k_in     = k_ff + 1'b1;
               base_in  = bound[PW-1:0];
               first_in = 1'b0;
            end
         end
      end else if (desc_valid) begin
         desc_pop = 1'b1;
         cur_in   = desc;
         k_in     = desc.k_first;
         base_in  = desc.base_first;
         first_in = 1'b1;
         busy_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b0;
         ovalid_ff <= 1'b0;
      end else begin
         busy_ff   <= busy_in;
         ovalid_ff <= ovalid_in;
      end
      cur_ff    <= cur_in;
      k_ff      <= k_in;
      base_ff   <= base_in;
      first_ff  <= first_in;
      opiece_ff <= opiece_in;
   end

   assign rsp_valid = ovalid_ff;
   assign rsp_piece = opiece_ff;

endmodule

>>> design/rank_task_range_partitioner_unit.sv
// Top level of the rank task range partitioner: csr registers, front, queue and back.
//
//  channel  dir  handshake            payload
//  req      in   req_tvalid/tready    tdata: worker_index
//  rsp      out  rsp_tvalid/tready    tdata: k_point, pair_low, pair_high, active_workers;
//                                     tuser: idle; tlast: last_piece
//  csr      in   csr_wr_en            csr_index, csr_wdata
//
//  After a request is taken the front runs no division when it ends idle, two on the
//  shared divider when the workers do not outnumber the k-points and three otherwise,
//  each at two quotient bits a cycle; req_tready returns once the descriptor is queued.
//  The back loads each descriptor, then emits one piece per cycle while rsp_tready holds.
//  A two-entry queue lets the front classify the next request while pieces drain.
//  Reset is synchronous and clears the csr registers to zero and both channels to empty.
//  A stalled rsp_tready holds the result register and, once the queue fills, req_tready.
module rank_task_range_partitioner_unit #(
   parameter int MAX_K_POINTS = rtrp_pkg::DEF_MAX_K_POINTS,
   parameter int MAX_ATOMS    = rtrp_pkg::DEF_MAX_ATOMS,
   parameter int MAX_WORKERS  = rtrp_pkg::DEF_MAX_WORKERS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [rtrp_pkg::REQ_TDATA_W-1:0] req_tdata,   // [9:0] worker_index
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [6:0] k_point, [14:7] pair_low, [23:15] pair_high, [34:24] active_workers
   output logic [rtrp_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output logic                             rsp_tlast,   // last_piece
   output logic                             rsp_tuser,   // idle
   input  logic                             csr_wr_en,
   input  logic [rtrp_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [rtrp_pkg::WORKER_W-1:0]    csr_wdata
);

   localparam int KW = rtrp_pkg::K_W;
   localparam int AW = rtrp_pkg::ATOM_W;
   localparam int WW = rtrp_pkg::WORKER_W;

   logic [KW-1:0] num_k_points_ff;
   logic [AW-1:0] num_atoms_ff;
   logic [WW-1:0] num_workers_ff;

   logic                     desc_valid, desc_full, desc_pop, desc_avail;
   rtrp_pkg::rtrp_desc_type  desc_push, desc_head;
   rtrp_pkg::rtrp_piece_type piece;

   // saturate each register at its bound
   always_ff @(posedge clock) begin
      if (reset) begin
         num_k_points_ff <= '0;
         num_atoms_ff    <= '0;
         num_workers_ff  <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            rtrp_pkg::CSR_NUM_K_POINTS: begin
               num_k_points_ff <= (int'(csr_wdata[KW-1:0]) > MAX_K_POINTS) ?
                                  KW'(MAX_K_POINTS) : csr_wdata[KW-1:0];
            end
            rtrp_pkg::CSR_NUM_ATOMS: begin
               num_atoms_ff <= (int'(csr_wdata[AW-1:0]) > MAX_ATOMS) ?
                               AW'(MAX_ATOMS) : csr_wdata[AW-1:0];
            end
            rtrp_pkg::CSR_NUM_WORKERS: begin
               num_workers_ff <= (int'(csr_wdata) > MAX_WORKERS) ?
                                 WW'(MAX_WORKERS) : csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   rtrp_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_tvalid),
      .req_ready    (req_tready),
      .worker_index (req_tdata[rtrp_pkg::INDEX_W-1:0]),
      .num_k_points (num_k_points_ff),
      .num_atoms    (num_atoms_ff),
      .num_workers  (num_workers_ff),
      .desc_valid   (desc_valid),
      .desc_full    (desc_full),
      .desc         (desc_push)
   );

   rtrp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (desc_valid),
      .push_data (desc_push),
      .full      (desc_full),
      .pop       (desc_pop),
      .pop_data  (desc_head),
      .not_empty (desc_avail)
   );

   rtrp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .desc_valid (desc_avail),
      .desc       (desc_head),
      .desc_pop   (desc_pop),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_piece  (piece)
   );

   assign rsp_tdata = {5'b0, piece.active_workers, piece.pair_high, piece.pair_low,
                       piece.k_point};
   assign rsp_tlast = piece.last_piece;
   assign rsp_tuser = piece.idle;

   // an idle word closes its request
   a_idle_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast)
      else $error("idle word without last flag");

   // a work piece names a real k-point
   a_piece_has_k: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[6:0] != 7'd0)
      else $error("work piece with k_point zero");

   // a work piece covers at least one pair
   a_piece_nonempty: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser && rsp_tdata[23:15] != 9'd0 |->
         {1'b0, rsp_tdata[14:7]} < rsp_tdata[23:15])
      else $error("work piece with empty pair range");

   // a queued descriptor is there to pop on the next cycle
   a_queue_source: assert property (@(posedge clock) disable iff (reset)
      desc_valid && !desc_full |=> desc_avail)
      else $error("descriptor lost on push");

endmodule

>>> tb/tb_rank_task_range_partitioner_unit.sv
// Self-checking testbench of the rank task range partitioner: directed and random requests.
`timescale 1ns / 100ps

module tb_rank_task_range_partitioner_unit;

   localparam int          MAX_PIECES    = 64;
   localparam int          SETTLE_CYCLES = 80;
   localparam int          CYCLE_LIMIT   = 1000000;
   localparam logic [rtrp_pkg::CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   logic                             clock       = 1'b0;
   logic                             reset       = 1'b1;
   logic                             req_tvalid  = 1'b0;
   logic                             req_tready;
   logic [rtrp_pkg::REQ_TDATA_W-1:0] req_tdata   = '0;
   logic                             rsp_tvalid;
   logic                             rsp_tready  = 1'b0;
   logic [rtrp_pkg::RSP_TDATA_W-1:0] rsp_tdata;
   logic                             rsp_tlast;
   logic                             rsp_tuser;
   logic                             csr_wr_en   = 1'b0;
   logic [rtrp_pkg::CSR_IDX_W-1:0]   csr_index   = '0;
   logic [rtrp_pkg::WORKER_W-1:0]    csr_wdata   = '0;

   // partition settings as the block should hold them
   int unsigned            cfg_k_points;
   int unsigned            cfg_atoms;
   int unsigned            cfg_workers;

   rtrp_pkg::rtrp_piece_type expected_pieces[$];
   int unsigned            mismatches  = 0;
   int unsigned            cycle_count = 0;
   int unsigned            stall_left  = 0;
   logic                   idling_on   = 1'b1;

   rank_task_range_partitioner_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // receiver back-pressure: random rsp_tready stalls while idling is on
   always @(posedge clock) begin
      if (reset || !idling_on) begin
         stall_left <= 0;
         rsp_tready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if ($urandom_range(0, 7) == 0) begin
         stall_left <= $urandom_range(0, 18);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   function automatic string piece_text(input rtrp_pkg::rtrp_piece_type p);
      return $sformatf("k=%0d lo=%0d hi=%0d act=%0d idle=%0d last=%0d", p.k_point,
                       p.pair_low, p.pair_high, p.active_workers, p.idle, p.last_piece);
   endfunction

   always @(posedge clock) begin : check_pieces
      rtrp_pkg::rtrp_piece_type got;
      rtrp_pkg::rtrp_piece_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.k_point        = rsp_tdata[6:0];
         got.pair_low       = rsp_tdata[14:7];
         got.pair_high      = rsp_tdata[23:15];
         got.active_workers = rsp_tdata[34:24];
         got.idle           = rsp_tuser;
         got.last_piece     = rsp_tlast;
         if (expected_pieces.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected word: %s", piece_text(got));
         end else begin
            want = expected_pieces.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %s, actual %s", piece_text(want),
                           piece_text(got));
            end
         end
      end
   end

   task automatic add_piece(input int unsigned kp, input int unsigned plo,
                            input int unsigned phi, input int unsigned act,
                            input logic idle, input logic last);
      rtrp_pkg::rtrp_piece_type p;
      p.k_point        = kp[rtrp_pkg::KP_W-1:0];
      p.pair_low       = plo[rtrp_pkg::PLO_W-1:0];
      p.pair_high      = phi[rtrp_pkg::PHI_W-1:0];
      p.active_workers = act[rtrp_pkg::ACT_W-1:0];
      p.idle           = idle;
      p.last_piece     = last;
      expected_pieces  = {expected_pieces, p};
   endtask

   // work out the pieces one worker receives under the current settings
   task automatic predict_pieces(input logic [rtrp_pkg::INDEX_W-1:0] worker);
      int unsigned kk, pp, ww, tt, act, lo, hi, ik, bound, stop, n;
      kk = cfg_k_points;
      pp = cfg_atoms * cfg_atoms;
      ww = cfg_workers;
      n  = 0;
      if (kk != 0 && pp != 0 && ww != 0) begin
         if (ww <= kk) begin
            if (worker < ww) begin
               lo = kk * worker / ww;
               hi = kk * (worker + 1) / ww;
               for (ik = lo; ik < hi && n < MAX_PIECES; ik++) begin
                  add_piece(ik + 1, 0, pp, ww, 1'b0, ik + 1 == hi);
                  n++;
               end
            end
         end else begin
            tt  = kk * pp;
            act = ww < tt ? ww : tt;
            if (worker < act) begin
               lo = tt * worker / act;
               hi = tt * (worker + 1) / act;
               // cut at k-point boundaries
               while (lo < hi && n < MAX_PIECES) begin
                  ik    = lo / pp;
                  bound = (ik + 1) * pp;
                  stop  = hi < bound ? hi : bound;
                  add_piece(ik + 1, lo % pp, stop - ik * pp, act, 1'b0, stop == hi);
                  n++;
                  lo = stop;
               end
            end
         end
      end
      if (n == 0)
         add_piece(0, 0, 0, 0, 1'b1, 1'b1);
   endtask

   task automatic request_pieces(input int unsigned worker);
      if (idling_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(rtrp_pkg::REQ_TDATA_W-rtrp_pkg::INDEX_W){1'b0}},
                     worker[rtrp_pkg::INDEX_W-1:0]};
      do @(posedge clock); while (!req_tready);
      predict_pieces(worker[rtrp_pkg::INDEX_W-1:0]);
   endtask

   // hold requests off until every expected word has come back
   task automatic wait_pieces_drained();
      req_tvalid <= 1'b0;
      while (expected_pieces.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [rtrp_pkg::CSR_IDX_W-1:0] idx,
                            input int unsigned value);
      int unsigned v;
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[rtrp_pkg::WORKER_W-1:0];
      @(posedge clock);
      case (idx)
         rtrp_pkg::CSR_NUM_K_POINTS: begin
            v = value & 'h7F;
            cfg_k_points = v > rtrp_pkg::DEF_MAX_K_POINTS ? rtrp_pkg::DEF_MAX_K_POINTS : v;
         end
         rtrp_pkg::CSR_NUM_ATOMS: begin
            v = value & 'h1F;
            cfg_atoms = v > rtrp_pkg::DEF_MAX_ATOMS ? rtrp_pkg::DEF_MAX_ATOMS : v;
         end
         rtrp_pkg::CSR_NUM_WORKERS: begin
            v = value & 'h7FF;
            cfg_workers = v > rtrp_pkg::DEF_MAX_WORKERS ? rtrp_pkg::DEF_MAX_WORKERS : v;
         end
         default: ;
      endcase
   endtask

   task automatic program_partition(input int unsigned k, input int unsigned atoms,
                                    input int unsigned workers);
      wait_pieces_drained();
      write_reg(rtrp_pkg::CSR_NUM_K_POINTS, k);
      write_reg(rtrp_pkg::CSR_NUM_ATOMS, atoms);
      write_reg(rtrp_pkg::CSR_NUM_WORKERS, workers);
      csr_wr_en <= 1'b0;
   endtask

   task automatic test_reset_state();
      request_pieces(0);
   endtask

   task automatic test_zero_sizes();
      program_partition(0, 16, 4);
      request_pieces(0);
      program_partition(8, 0, 4);
      request_pieces(0);
      program_partition(8, 4, 0);
      request_pieces(0);
   endtask

   task automatic test_register_saturation();
      program_partition(127, 31, 2047);
      request_pieces(0);
      request_pieces(1023);
      // an unused index must leave the settings alone
      wait_pieces_drained();
      write_reg(CSR_UNUSED, 2047);
      csr_wr_en <= 1'b0;
      request_pieces(5);
   endtask

   task automatic test_k_split();
      program_partition(64, 16, 1);
      request_pieces(0);
      request_pieces(1);
      program_partition(64, 16, 64);
      request_pieces(63);
      program_partition(10, 3, 4);
      request_pieces(0);
      request_pieces(1);
      request_pieces(3);
      request_pieces(4);
   endtask

   task automatic test_task_split();
      int unsigned w;
      program_partition(3, 2, 20);
      request_pieces(0);
      request_pieces(11);
      request_pieces(12);
      program_partition(3, 3, 5);
      for (w = 0; w < 5; w++)
         request_pieces(w);
      request_pieces(1023);
   endtask

   task automatic test_random_partitions();
      int unsigned k, atoms, workers, kk, pp, act, w, phase, i;
      for (phase = 0; phase < 11; phase++) begin
         case (phase)
            0: begin k = 64; atoms = 16; workers = 1024; end
            1: begin k = 64; atoms = 16; workers = 1;    end
            2: begin k = 1;  atoms = 1;  workers = 1;    end
            3: begin k = 1;  atoms = 1;  workers = 1024; end
            default: begin
               k     = $urandom_range(0, 9) == 0 ? $urandom_range(65, 127)
                                                 : $urandom_range(1, 64);
               atoms = $urandom_range(0, 9) == 0 ? $urandom_range(17, 31)
                                                 : $urandom_range(1, 16);
               kk    = k > 64 ? 64 : k;
               workers = $urandom_range(0, 1) ? $urandom_range(1, kk)
                                              : $urandom_range(1, 2047);
               if ($urandom_range(0, 11) == 0)
                  atoms = 0;
            end
         endcase
         program_partition(k, atoms, workers);
         // last phase runs without idling on either side
         if (phase == 10)
            idling_on <= 1'b0;
         kk = cfg_k_points;
         pp = cfg_atoms * cfg_atoms;
         if (kk == 0 || pp == 0 || cfg_workers == 0)
            act = 0;
         else if (cfg_workers <= kk)
            act = cfg_workers;
         else
            act = cfg_workers < kk * pp ? cfg_workers : kk * pp;
         for (i = 0; i < 8; i++) begin
            if (phase == 5 && i == 5)
               wait_pieces_drained();
            if (act == 0 || $urandom_range(0, 4) == 0)
               w = $urandom_range(0, 1023);
            else
               w = $urandom_range(0, act > 1024 ? 1023 : act - 1);
            request_pieces(w);
         end
      end
   endtask

   initial begin
      cfg_k_points = 0;
      cfg_atoms    = 0;
      cfg_workers  = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_state();
      test_zero_sizes();
      test_register_saturation();
      test_k_split();
      test_task_split();
      test_random_partitions();
      wait_pieces_drained();
      if (expected_pieces.size() != 0)
         mismatches++;
      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

>>> sim.f
design/rtrp_pkg.sv
design/rtrp_div.sv
design/rtrp_queue.sv
design/rtrp_front.sv
design/rtrp_back.sv
design/rank_task_range_partitioner_unit.sv
tb/tb_rank_task_range_partitioner_unit.sv
